FILE: src/pec_pkg.sv
// Shared types and constants for the prefix code encoder and packer.
`default_nettype none
package pec_pkg;

    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int ENTRY_W   = 21;

    // Entry layout
    localparam int SYM_LSB   = 13;
    localparam int LEN_LSB   = 9;
    localparam int LEN_FLD_W = 4;
    localparam int CODE_FLD_W = 9;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       stream_end;
        logic [2:0] pad_bits;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] data;
    } t_cfg_wr;

endpackage
`default_nettype wire

FILE: src/pec_table.sv
// Code table registers and priority symbol lookup.
`default_nettype none
module pec_table #(
    parameter int TABLE_ENTRIES = 8,
    parameter int MAX_CODE_BITS = 9,
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire pec_pkg::t_cfg_wr    i_cfg,
    input  wire [7:0]                i_symbol,
    output logic                     o_hit,
    output logic [LEN_W-1:0]         o_len,
    output logic [MAX_CODE_BITS-1:0] o_code_aligned
);

    logic [pec_pkg::ENTRY_W-1:0] r_entry [pec_pkg::NUM_REGS];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pec_pkg::NUM_REGS; i++) begin
                r_entry[i] <= '0;
            end
        end else if (i_cfg.we) begin
            r_entry[i_cfg.idx] <= i_cfg.data;
        end
    end

    logic [pec_pkg::LEN_FLD_W-1:0]  hit_len_raw;
    logic [pec_pkg::CODE_FLD_W-1:0] hit_code_raw;
    logic [MAX_CODE_BITS-1:0]       masked;
    logic [LEN_W-1:0]               shift_amt;

    // Priority search: scan downward so the lowest matching entry wins
    always_comb begin
        o_hit        = 1'b0;
        hit_len_raw  = '0;
        hit_code_raw = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_entry[i][pec_pkg::LEN_LSB +: pec_pkg::LEN_FLD_W] != '0 &&
                r_entry[i][pec_pkg::SYM_LSB +: 8] == i_symbol) begin
                o_hit        = 1'b1;
                hit_len_raw  = r_entry[i][pec_pkg::LEN_LSB +: pec_pkg::LEN_FLD_W];
                hit_code_raw = r_entry[i][pec_pkg::CODE_FLD_W-1:0];
            end
        end
    end

    // Saturate length, mask code, left-align it for MSB-first shifting
    always_comb begin
        if (32'(hit_len_raw) > MAX_CODE_BITS) begin
            o_len = LEN_W'(MAX_CODE_BITS);
        end else begin
            o_len = LEN_W'(hit_len_raw);
        end
        for (int j = 0; j < MAX_CODE_BITS; j++) begin
            masked[j] = hit_code_raw[j] & (j < 32'(o_len));
        end
        shift_amt      = LEN_W'(MAX_CODE_BITS) - o_len;
        o_code_aligned = masked << shift_amt;
    end

endmodule
`default_nettype wire

FILE: src/pec_packer.sv
// Bit-serial packer: shifts code bits into the pending byte and emits bytes.
`default_nettype none
module pec_packer #(
    parameter int MAX_CODE_BITS = 9,
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire                      i_kind,
    input  wire                      i_hit,
    input  wire [LEN_W-1:0]          i_len,
    input  wire [MAX_CODE_BITS-1:0]  i_code_aligned,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output pec_pkg::t_out_item       o_out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [6:0]               r_bits, n_bits;
    logic [2:0]               r_cnt, n_cnt;
    logic [MAX_CODE_BITS-1:0] r_code, n_code;
    logic [LEN_W-1:0]         r_left, n_left;
    logic                     r_out_valid, n_out_valid;
    pec_pkg::t_out_item       r_out, n_out;

    logic       accept;
    logic       out_free;
    logic       code_bit;
    logic [2:0] pad;
    logic [7:0] flush_byte;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign code_bit    = r_code[MAX_CODE_BITS-1];
    assign pad         = 3'd0 - r_cnt;
    assign flush_byte  = {1'b0, r_bits} << pad;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_code      = r_code;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == pec_pkg::KIND_FLUSH) begin
                        if (r_cnt != 3'd0) begin
                            n_state = ST_FLUSH;
                        end
                    end else if (i_hit) begin
                        n_code  = i_code_aligned;
                        n_left  = i_len;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // a full byte waits for the output register to free up
                if (r_cnt != 3'd7 || out_free) begin
                    n_bits = {r_bits[5:0], code_bit};
                    n_cnt  = r_cnt + 3'd1;
                    n_code = r_code << 1;
                    n_left = r_left - LEN_W'(1);
                    if (r_cnt == 3'd7) begin
                        n_out_valid       = 1'b1;
                        n_out.packed_byte = {r_bits, code_bit};
                        n_out.stream_end  = 1'b0;
                        n_out.pad_bits    = 3'd0;
                        // another byte follows only if eight more bits remain
                        n_out.last_of_run = (32'(r_left) <= 32'd8);
                    end
                    if (r_left == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.packed_byte = flush_byte;
                    n_out.stream_end  = 1'b1;
                    n_out.pad_bits    = pad;
                    n_out.last_of_run = 1'b1;
                    n_cnt             = 3'd0;
                    n_bits            = '0;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 3'd0;
            r_bits      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bits      <= n_bits;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

FILE: src/prefix_code_encoder_packer.sv
// Top level of the prefix code encoder and bit packer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries items of kind
// encode (a symbol byte) or flush. Each encode item is matched against the
// eight table entries written through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the lowest matching entry with nonzero length wins. Its code
// bits enter the pending byte one bit per clock, MSB first, except that the
// bit that fills a byte waits while the output register still holds a
// stalled byte. No new item is taken until the last code bit is shifted in
// or the flush byte is registered. The shift loop through the pending byte
// sets the bit rate. Output channel (o_out_valid / i_out_stall / o_out_data)
// presents each completed byte from an output register right after the edge
// that shifts in its last bit; a flush byte, padded with zeros and flagged as
// stream end, is registered from the flush state once the output register
// is free. When the receiver stalls, the held byte stays put and shifting
// pauses only when the next byte fills. Reset clears the table, the pending
// byte and all valid flags; the user must write the table only while the
// block is idle, which the block itself does not enforce.
`default_nettype none
module prefix_code_encoder_packer #(
    parameter int TABLE_ENTRIES = 8,
    parameter int MAX_CODE_BITS = 9
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [pec_pkg::IDX_W-1:0]           i_cfg_idx,
    input  wire [pec_pkg::ENTRY_W-1:0]         i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire pec_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output pec_pkg::t_out_item                 o_out_data
);

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    pec_pkg::t_cfg_wr         cfg;
    logic                     hit;
    logic [LEN_W-1:0]         len;
    logic [MAX_CODE_BITS-1:0] code_aligned;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Table and lookup
    pec_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_symbol       (i_in_data.symbol),
        .o_hit          (hit),
        .o_len          (len),
        .o_code_aligned (code_aligned)
    );

    // Serial packer
    pec_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_in_data.kind),
        .i_hit          (hit),
        .i_len          (len),
        .i_code_aligned (code_aligned),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
`default_nettype wire
